[hdl/poly_counter_noise_and_prescaler_unit_macros.svh]
// Assertion macros for the polynomial counter and prescaler unit.
`ifndef POLY_COUNTER_NOISE_AND_PRESCALER_UNIT_MACROS_SVH
`define POLY_COUNTER_NOISE_AND_PRESCALER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PCNP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcnp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCNP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcnp next-cycle check failed");

`else

`define PCNP_ASSERT_SAME(lbl, ante, cons)
`define PCNP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hdl/pcnp_pkg.sv]
// Constants and types for the polynomial counter and prescaler unit.
package pcnp_pkg;

  localparam int unsigned FastW = 5;
  localparam int unsigned SlowW = 7;

  localparam logic [FastW-1:0] FastReset  = 5'd19;
  localparam logic [FastW-1:0] FastReload = 5'd28;
  localparam logic [SlowW-1:0] SlowReset  = 7'd78;
  localparam logic [SlowW-1:0] SlowReload = 7'd114;

  localparam logic [3:0]  Lfsr4Reset  = 4'h0f;
  localparam logic [4:0]  Lfsr5Reset  = 5'h1f;
  localparam logic [8:0]  Lfsr9Reset  = 9'h1ff;
  localparam logic [16:0] Lfsr17Reset = 17'h1ffff;

  localparam int unsigned Tap4  = 1;
  localparam int unsigned Tap5  = 2;
  localparam int unsigned Tap9  = 5;
  localparam int unsigned Tap17 = 5;

  localparam logic [3:0] Hist5ResetLow = 4'hf;

  typedef struct packed {
    logic       pulse_fast;
    logic       pulse_slow;
    logic [7:0] random_byte;
    logic       bit_four;
    logic       bit_five;
    logic       bit_nine;
    logic       bit_seventeen;
  } pcnp_result_t;

endpackage

[hdl/poly_counter_noise_and_prescaler_unit.sv]
// Top level: four-LFSR polynomial counter bank with two prescalers.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_enable_i, in_sample_phase_i
//  out     | output    | out_valid_o / out_ready_i | pulses, random byte, four history bits
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_random_from_nine_i
//
// One beat per cycle unless the output stalls: state is updated and the result registered
// on acceptance and shows in the next cycle. Throughput is set by the single output register.
// rst_ni clears all state but the result register to its reset values; cfg is always ready.
// A stalled output holds its beat; input is taken when the output register is free or drains.
`include "poly_counter_noise_and_prescaler_unit_macros.svh"

module poly_counter_noise_and_prescaler_unit
  import pcnp_pkg::*;
#(
  parameter int unsigned HISTORY_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_random_from_nine_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_enable_i,
  input  logic [4:0] in_sample_phase_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       pulse_fast_o,
  output logic       pulse_slow_o,
  output logic [7:0] random_byte_o,
  output logic       bit_four_o,
  output logic       bit_five_o,
  output logic       bit_nine_o,
  output logic       bit_seventeen_o
);

  localparam logic [HISTORY_BITS-1:0] Hist5Reset = {{(HISTORY_BITS-4){1'b0}}, Hist5ResetLow};

  logic                    from_nine_q;
  logic [FastW-1:0]        count_fast_q, count_fast_d;
  logic [SlowW-1:0]        count_slow_q, count_slow_d;
  logic [3:0]              lfsr4_q, lfsr4_d;
  logic [4:0]              lfsr5_q, lfsr5_d;
  logic [8:0]              lfsr9_q, lfsr9_d;
  logic [16:0]             lfsr17_q, lfsr17_d;
  logic [HISTORY_BITS-1:0] hist4_q, hist4_d;
  logic [HISTORY_BITS-1:0] hist5_q, hist5_d;
  logic [HISTORY_BITS-1:0] hist9_q, hist9_d;
  logic [HISTORY_BITS-1:0] hist17_q, hist17_d;
  logic [FastW-1:0]        fast_dec;
  logic [SlowW-1:0]        slow_dec;
  logic                    in_fire;
  logic                    out_valid_q;
  pcnp_result_t            res_d, res_q;
  logic [HISTORY_BITS-1:0] sh4, sh5, sh9, sh17;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    fast_dec = count_fast_q - 1'b1;
    slow_dec = count_slow_q - 1'b1;
    res_d.pulse_fast = 1'b0;
    res_d.pulse_slow = 1'b0;
    if (!in_enable_i) begin
      count_fast_d = FastReset;
      count_slow_d = SlowReset;
      lfsr4_d      = Lfsr4Reset;
      lfsr5_d      = Lfsr5Reset;
      lfsr9_d      = Lfsr9Reset;
      lfsr17_d     = Lfsr17Reset;
      hist4_d      = '0;
      hist5_d      = Hist5Reset;
      hist9_d      = '0;
      hist17_d     = '0;
    end else begin
      lfsr4_d  = {lfsr4_q[0] ^ lfsr4_q[Tap4], lfsr4_q[3:1]};
      lfsr5_d  = {lfsr5_q[0] ^ lfsr5_q[Tap5], lfsr5_q[4:1]};
      lfsr9_d  = {lfsr9_q[0] ^ lfsr9_q[Tap9], lfsr9_q[8:1]};
      lfsr17_d = {lfsr17_q[0] ^ lfsr17_q[Tap17], lfsr17_q[16:1]};
      hist4_d  = {hist4_q[HISTORY_BITS-2:0], ~lfsr4_d[0]};
      hist5_d  = {hist5_q[HISTORY_BITS-2:0], lfsr5_d[0]};
      hist9_d  = {hist9_q[HISTORY_BITS-2:0], ~lfsr9_d[0]};
      hist17_d = {hist17_q[HISTORY_BITS-2:0], ~lfsr17_d[0]};
      if (fast_dec == '0) begin
        count_fast_d     = FastReload;
        res_d.pulse_fast = 1'b1;
      end else begin
        count_fast_d = fast_dec;
      end
      if (slow_dec == '0) begin
        count_slow_d     = SlowReload;
        res_d.pulse_slow = 1'b1;
      end else begin
        count_slow_d = slow_dec;
      end
    end
    // phases past the history width shift everything out and read 0
    sh4  = hist4_d >> in_sample_phase_i;
    sh5  = hist5_d >> in_sample_phase_i;
    sh9  = hist9_d >> in_sample_phase_i;
    sh17 = hist17_d >> in_sample_phase_i;
    res_d.random_byte   = from_nine_q ? lfsr9_d[8:1] : lfsr17_d[16:9];
    res_d.bit_four      = sh4[0];
    res_d.bit_five      = sh5[0];
    res_d.bit_nine      = sh9[0];
    res_d.bit_seventeen = sh17[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_nine_q  <= 1'b0;
      count_fast_q <= FastReset;
      count_slow_q <= SlowReset;
      lfsr4_q      <= Lfsr4Reset;
      lfsr5_q      <= Lfsr5Reset;
      lfsr9_q      <= Lfsr9Reset;
      lfsr17_q     <= Lfsr17Reset;
      hist4_q      <= '0;
      hist5_q      <= Hist5Reset;
      hist9_q      <= '0;
      hist17_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        from_nine_q <= cfg_random_from_nine_i;
      end
      if (in_fire) begin
        count_fast_q <= count_fast_d;
        count_slow_q <= count_slow_d;
        lfsr4_q      <= lfsr4_d;
        lfsr5_q      <= lfsr5_d;
        lfsr9_q      <= lfsr9_d;
        lfsr17_q     <= lfsr17_d;
        hist4_q      <= hist4_d;
        hist5_q      <= hist5_d;
        hist9_q      <= hist9_d;
        hist17_q     <= hist17_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pulse_fast_o    = res_q.pulse_fast;
  assign pulse_slow_o    = res_q.pulse_slow;
  assign random_byte_o   = res_q.random_byte;
  assign bit_four_o      = res_q.bit_four;
  assign bit_five_o      = res_q.bit_five;
  assign bit_nine_o      = res_q.bit_nine;
  assign bit_seventeen_o = res_q.bit_seventeen;

  `PCNP_ASSERT_NEXT(a_accept_gives_beat, in_fire, out_valid_o)
  `PCNP_ASSERT_SAME(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  `PCNP_ASSERT_NEXT(a_disabled_no_pulse, in_fire && !in_enable_i,
                    !pulse_fast_o && !pulse_slow_o)
  `PCNP_ASSERT_NEXT(a_fast_pulse_reload, in_fire,
                    pulse_fast_o == (count_fast_q == FastReload))

endmodule
